FILE: sv/lvrk_pkg.sv
// ----------------------------------------------------------------------------
// lvrk_pkg
// Shared types, constants and the micro-program of the Lotka-Volterra RK4
// integrator: operand and destination codes, control word, sequencer states.
// ----------------------------------------------------------------------------
package lvrk_pkg;

    // Word format of the populations and coefficients
    localparam int WORD_BITS = 32;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int STEP_BITS = 31;
    localparam int H6_BITS   = 29;

    localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // h/6 as a multiply by a rounded-up reciprocal, exact for 31-bit h
    localparam logic [31:0] H6_RECIP = 32'd2863311531;
    localparam int          H6_SHIFT = 34;

    // Register reset values (Q16.16)
    localparam logic [WORD_BITS-1:0] RST_PREY_GROWTH    = 32'd43691;
    localparam logic [WORD_BITS-1:0] RST_PREDATION_RATE = 32'd87381;
    localparam logic [WORD_BITS-1:0] RST_PREDATOR_GAIN  = 32'd65536;
    localparam logic [WORD_BITS-1:0] RST_PREDATOR_DEATH = 32'd65536;
    localparam logic [STEP_BITS-1:0] RST_STEP_SIZE      = 31'd6554;
    localparam logic [H6_BITS-1:0]   RST_STEP_SIXTH     = 29'd1092;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PREY_GROWTH    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PREDATION_RATE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PREDATOR_GAIN  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PREDATOR_DEATH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_SIZE      = 3'd4;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // Scratch store and program counter
    localparam int TMP_DEPTH = 16;
    localparam int TMP_AW    = $clog2(TMP_DEPTH);
    localparam int PC_BITS   = 5;
    localparam int PASS_BITS = 2;

    typedef logic [TMP_AW-1:0]  tmp_addr_t;
    typedef logic [PC_BITS-1:0] pc_t;

    localparam tmp_addr_t T_PX = 4'd0;
    localparam tmp_addr_t T_PY = 4'd1;
    localparam tmp_addr_t T_M1 = 4'd2;
    localparam tmp_addr_t T_M2 = 4'd3;
    localparam tmp_addr_t T_KA = 4'd4;
    localparam tmp_addr_t T_KB = 4'd5;
    localparam tmp_addr_t T_SA = 4'd6;
    localparam tmp_addr_t T_SB = 4'd7;
    localparam tmp_addr_t T_D  = 4'd8;

    // Program labels
    localparam pc_t PC_RATE   = 5'd2;
    localparam pc_t PC_UPDATE = 5'd16;
    localparam pc_t PC_FIRST  = 5'd20;
    localparam pc_t PC_LAST   = 5'd22;

    // Pass numbers of the four slope evaluations
    localparam logic [PASS_BITS-1:0] PASS_FIRST  = 2'd0;
    localparam logic [PASS_BITS-1:0] PASS_FULL_H = 2'd2;
    localparam logic [PASS_BITS-1:0] PASS_LAST   = 2'd3;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_ADD,
        OP_SUB,
        OP_MUL
    } op_t;

    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_TMP,
        SRC_ALPHA,
        SRC_BETA,
        SRC_DELTA,
        SRC_GAMMA,
        SRC_HS,
        SRC_H6,
        SRC_X,
        SRC_Y
    } src_t;

    typedef enum logic [1:0] {
        DST_TMP,
        DST_X,
        DST_Y
    } dst_t;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_ALWAYS,
        BR_FIRST,
        BR_LAST,
        BR_END
    } br_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MULW,
        ST_FIN
    } st_t;

    typedef struct packed {
        op_t       op;
        src_t      a_src;
        tmp_addr_t a_addr;
        src_t      b_src;
        tmp_addr_t b_addr;
        dst_t      dst;
        tmp_addr_t d_addr;
        br_t       br;
        logic      bump;
        pc_t       target;
    } uword_t;

    // Control from the sequencer to the datapath
    typedef struct packed {
        logic   load;
        logic   start;
        logic   exec;
        logic   mul_wb;
        logic   use_full_h;
        uword_t uw;
    } ctrl_t;

    function automatic uword_t mk(input op_t op, input src_t as, input tmp_addr_t aa,
                                  input src_t bs, input tmp_addr_t ba, input dst_t ds,
                                  input tmp_addr_t da, input br_t br, input logic bump,
                                  input pc_t target);
        uword_t w;
        w.op     = op;
        w.a_src  = as;
        w.a_addr = aa;
        w.b_src  = bs;
        w.b_addr = ba;
        w.dst    = ds;
        w.d_addr = da;
        w.br     = br;
        w.bump   = bump;
        w.target = target;
        return w;
    endfunction

    // Micro-program: one RK4 step. Slopes are evaluated in four passes over
    // the shared rate body; the pass number picks the follow-up code.
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        unique case (pc)
            // copy the current point into the evaluation point
            5'd0:  w = mk(OP_ADD, SRC_X, T_PX, SRC_ZERO, T_PX, DST_TMP, T_PX, BR_NEXT, 1'b0, '0);
            5'd1:  w = mk(OP_ADD, SRC_Y, T_PY, SRC_ZERO, T_PY, DST_TMP, T_PY, BR_NEXT, 1'b0, '0);
            // prey slope: alpha*x - (beta*x)*y
            5'd2:  w = mk(OP_MUL, SRC_ALPHA, T_PX, SRC_TMP, T_PX, DST_TMP, T_M1, BR_NEXT, 1'b0, '0);
            5'd3:  w = mk(OP_MUL, SRC_BETA, T_PX, SRC_TMP, T_PX, DST_TMP, T_M2, BR_NEXT, 1'b0, '0);
            5'd4:  w = mk(OP_MUL, SRC_TMP, T_M2, SRC_TMP, T_PY, DST_TMP, T_M2, BR_NEXT, 1'b0, '0);
            5'd5:  w = mk(OP_SUB, SRC_TMP, T_M1, SRC_TMP, T_M2, DST_TMP, T_KA, BR_NEXT, 1'b0, '0);
            // predator slope: (delta*x)*y - gamma*y
            5'd6:  w = mk(OP_MUL, SRC_DELTA, T_PX, SRC_TMP, T_PX, DST_TMP, T_M1, BR_NEXT, 1'b0, '0);
            5'd7:  w = mk(OP_MUL, SRC_TMP, T_M1, SRC_TMP, T_PY, DST_TMP, T_M1, BR_NEXT, 1'b0, '0);
            5'd8:  w = mk(OP_MUL, SRC_GAMMA, T_PY, SRC_TMP, T_PY, DST_TMP, T_M2, BR_NEXT, 1'b0, '0);
            5'd9:  w = mk(OP_SUB, SRC_TMP, T_M1, SRC_TMP, T_M2, DST_TMP, T_KB, BR_NEXT, 1'b0, '0);
            // dispatch on pass
            5'd10: w = mk(OP_NOP, SRC_ZERO, T_PX, SRC_ZERO, T_PX, DST_TMP, T_PX, BR_FIRST, 1'b0,
                          PC_FIRST);
            5'd11: w = mk(OP_NOP, SRC_ZERO, T_PX, SRC_ZERO, T_PX, DST_TMP, T_PX, BR_LAST, 1'b0,
                          PC_LAST);
            // middle passes: add twice the slope to the sums
            5'd12: w = mk(OP_ADD, SRC_TMP, T_KA, SRC_TMP, T_KA, DST_TMP, T_D, BR_NEXT, 1'b0, '0);
            5'd13: w = mk(OP_ADD, SRC_TMP, T_SA, SRC_TMP, T_D, DST_TMP, T_SA, BR_NEXT, 1'b0, '0);
            5'd14: w = mk(OP_ADD, SRC_TMP, T_KB, SRC_TMP, T_KB, DST_TMP, T_D, BR_NEXT, 1'b0, '0);
            5'd15: w = mk(OP_ADD, SRC_TMP, T_SB, SRC_TMP, T_D, DST_TMP, T_SB, BR_NEXT, 1'b0, '0);
            // next evaluation point from the start point
            5'd16: w = mk(OP_MUL, SRC_HS, T_KA, SRC_TMP, T_KA, DST_TMP, T_M1, BR_NEXT, 1'b0, '0);
            5'd17: w = mk(OP_ADD, SRC_X, T_M1, SRC_TMP, T_M1, DST_TMP, T_PX, BR_NEXT, 1'b0, '0);
            5'd18: w = mk(OP_MUL, SRC_HS, T_KB, SRC_TMP, T_KB, DST_TMP, T_M1, BR_NEXT, 1'b0, '0);
            5'd19: w = mk(OP_ADD, SRC_Y, T_M1, SRC_TMP, T_M1, DST_TMP, T_PY, BR_ALWAYS, 1'b1,
                          PC_RATE);
            // first pass: start the sums
            5'd20: w = mk(OP_ADD, SRC_TMP, T_KA, SRC_ZERO, T_KA, DST_TMP, T_SA, BR_NEXT, 1'b0, '0);
            5'd21: w = mk(OP_ADD, SRC_TMP, T_KB, SRC_ZERO, T_KB, DST_TMP, T_SB, BR_ALWAYS, 1'b0,
                          PC_UPDATE);
            // last pass: close the sums and advance the populations
            5'd22: w = mk(OP_ADD, SRC_TMP, T_SA, SRC_TMP, T_KA, DST_TMP, T_SA, BR_NEXT, 1'b0, '0);
            5'd23: w = mk(OP_ADD, SRC_TMP, T_SB, SRC_TMP, T_KB, DST_TMP, T_SB, BR_NEXT, 1'b0, '0);
            5'd24: w = mk(OP_MUL, SRC_H6, T_SA, SRC_TMP, T_SA, DST_TMP, T_M1, BR_NEXT, 1'b0, '0);
            5'd25: w = mk(OP_ADD, SRC_X, T_M1, SRC_TMP, T_M1, DST_X, T_M1, BR_NEXT, 1'b0, '0);
            5'd26: w = mk(OP_MUL, SRC_H6, T_SB, SRC_TMP, T_SB, DST_TMP, T_M1, BR_NEXT, 1'b0, '0);
            5'd27: w = mk(OP_ADD, SRC_Y, T_M1, SRC_TMP, T_M1, DST_Y, T_M1, BR_END, 1'b0, '0);
            default: w = mk(OP_NOP, SRC_ZERO, T_PX, SRC_ZERO, T_PX, DST_TMP, T_PX, BR_END, 1'b0,
                            '0);
        endcase
        return w;
    endfunction

endpackage

FILE: sv/lvrk_ram.sv
// ----------------------------------------------------------------------------
// lvrk_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lvrk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: sv/lvrk_seq.sv
// ----------------------------------------------------------------------------
// lvrk_seq
// Micro-sequencer: item handshake, program counter, pass counter and the
// per-instruction phase (operand read, execute, multiply write-back).
// ----------------------------------------------------------------------------
module lvrk_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            in_kind,
    input  logic            out_free,
    output logic            in_ready,
    output logic            out_load,
    output lvrk_pkg::ctrl_t ctrl
);

    lvrk_pkg::st_t                     state_reg, state_next;
    lvrk_pkg::pc_t                     pc_reg, pc_next;
    logic [lvrk_pkg::PASS_BITS-1:0]    pass_reg, pass_next;
    lvrk_pkg::uword_t                  uw;
    logic                              accept;
    logic                              instr_done;
    logic                              taken;
    logic                              is_end;

    // fetch the current control word
    assign uw     = lvrk_pkg::ucode(pc_reg);
    assign accept = in_valid && in_ready;
    assign is_end = (uw.br == lvrk_pkg::BR_END);

    assign instr_done = (state_reg == lvrk_pkg::ST_EXEC && uw.op != lvrk_pkg::OP_MUL)
                     || (state_reg == lvrk_pkg::ST_MULW);

    // resolve the branch condition
    always_comb begin
        unique case (uw.br)
            lvrk_pkg::BR_ALWAYS: taken = 1'b1;
            lvrk_pkg::BR_FIRST:  taken = (pass_reg == lvrk_pkg::PASS_FIRST);
            lvrk_pkg::BR_LAST:   taken = (pass_reg == lvrk_pkg::PASS_LAST);
            default:             taken = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lvrk_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (in_kind == lvrk_pkg::KIND_STEP) ? lvrk_pkg::ST_READ
                                                                  : lvrk_pkg::ST_FIN;
                end
            end
            lvrk_pkg::ST_READ: begin
                state_next = lvrk_pkg::ST_EXEC;
            end
            lvrk_pkg::ST_EXEC: begin
                if (uw.op == lvrk_pkg::OP_MUL) begin
                    state_next = lvrk_pkg::ST_MULW;
                end else if (is_end) begin
                    state_next = lvrk_pkg::ST_FIN;
                end else begin
                    state_next = lvrk_pkg::ST_READ;
                end
            end
            lvrk_pkg::ST_MULW: begin
                state_next = is_end ? lvrk_pkg::ST_FIN : lvrk_pkg::ST_READ;
            end
            lvrk_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = lvrk_pkg::ST_IDLE;
                end
            end
            default: state_next = lvrk_pkg::ST_IDLE;
        endcase
    end

    // advance program and pass counters
    always_comb begin
        pc_next   = pc_reg;
        pass_next = pass_reg;
        if (accept) begin
            pc_next   = '0;
            pass_next = '0;
        end else if (instr_done) begin
            pc_next   = taken ? uw.target : pc_reg + 1'b1;
            pass_next = pass_reg + {{(lvrk_pkg::PASS_BITS-1){1'b0}}, uw.bump};
        end
    end

    // outputs
    always_comb begin
        in_ready        = (state_reg == lvrk_pkg::ST_IDLE);
        out_load        = (state_reg == lvrk_pkg::ST_FIN) && out_free;
        ctrl.load       = accept && (in_kind == lvrk_pkg::KIND_LOAD);
        ctrl.start      = accept && (in_kind == lvrk_pkg::KIND_STEP);
        ctrl.exec       = (state_reg == lvrk_pkg::ST_EXEC);
        ctrl.mul_wb     = (state_reg == lvrk_pkg::ST_MULW);
        ctrl.use_full_h = (pass_reg == lvrk_pkg::PASS_FULL_H);
        ctrl.uw         = uw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lvrk_pkg::ST_IDLE;
            pc_reg    <= '0;
            pass_reg  <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

FILE: sv/lvrk_dp.sv
// ----------------------------------------------------------------------------
// lvrk_dp
// Datapath: coefficient registers, populations, scratch RAM, one shared
// saturating multiplier and one saturating adder/subtractor.
// ----------------------------------------------------------------------------
module lvrk_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lvrk_pkg::ctrl_t                     ctrl,
    input  logic                                cfg_we,
    input  logic [lvrk_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lvrk_pkg::WORD_BITS-1:0]      cfg_data,
    input  logic [lvrk_pkg::WORD_BITS-1:0]      prey_load,
    input  logic [lvrk_pkg::WORD_BITS-1:0]      predator_load,
    output logic [lvrk_pkg::WORD_BITS-1:0]      prey_level,
    output logic [lvrk_pkg::WORD_BITS-1:0]      predator_level,
    output logic                                saturated
);

    localparam int WB = lvrk_pkg::WORD_BITS;
    localparam int PB = lvrk_pkg::PROD_BITS;
    localparam int SB = lvrk_pkg::STEP_BITS;
    localparam int HB = lvrk_pkg::H6_BITS;

    logic [WB-1:0]          alpha_reg, beta_reg, delta_reg, gamma_reg;
    logic [SB-1:0]          step_reg;
    logic [HB-1:0]          h6_reg;
    logic [SB+32-1:0]       h6_prod;
    logic [WB-1:0]          x_reg, y_reg;
    logic                   sat_reg;
    logic [WB-1:0]          ram_a, ram_b;
    logic [WB-1:0]          hs;
    logic signed [WB-1:0]   a_op, b_op, b_eff;
    logic signed [PB-1:0]   prod_w;
    logic signed [PB-1:0]   prod_reg;
    logic                   p_neg;
    logic [PB-1:0]          p_mag, p_q, p_lim;
    logic                   mul_ovf;
    logic [WB-1:0]          mul_res;
    logic                   neg_sat;
    logic [WB:0]            sum;
    logic                   add_ovf;
    logic [WB-1:0]          add_res;
    logic                   is_alu;
    logic                   wr_en;
    logic [WB-1:0]          wr_data;

    // h/6 by reciprocal multiply, taken when the step size is written
    assign h6_prod = {32'b0, cfg_data[SB-1:0]} * {{SB{1'b0}}, lvrk_pkg::H6_RECIP};

    // step used by the evaluation point update: h/2, or h on the third pass
    assign hs = ctrl.use_full_h ? {{(WB-SB){1'b0}}, step_reg}
                                : {{(WB-SB+1){1'b0}}, step_reg[SB-1:1]};

    function automatic logic [WB-1:0] pick(input lvrk_pkg::src_t s, input logic [WB-1:0] rd,
                                           input logic [WB-1:0] alpha, input logic [WB-1:0] beta,
                                           input logic [WB-1:0] delta, input logic [WB-1:0] gamma,
                                           input logic [WB-1:0] hstep, input logic [HB-1:0] h6,
                                           input logic [WB-1:0] x, input logic [WB-1:0] y);
        logic [WB-1:0] v;
        unique case (s)
            lvrk_pkg::SRC_TMP:   v = rd;
            lvrk_pkg::SRC_ALPHA: v = alpha;
            lvrk_pkg::SRC_BETA:  v = beta;
            lvrk_pkg::SRC_DELTA: v = delta;
            lvrk_pkg::SRC_GAMMA: v = gamma;
            lvrk_pkg::SRC_HS:    v = hstep;
            lvrk_pkg::SRC_H6:    v = {{(WB-HB){1'b0}}, h6};
            lvrk_pkg::SRC_X:     v = x;
            lvrk_pkg::SRC_Y:     v = y;
            default:             v = '0;
        endcase
        return v;
    endfunction

    // operand select
    assign a_op = pick(ctrl.uw.a_src, ram_a, alpha_reg, beta_reg, delta_reg, gamma_reg, hs,
                       h6_reg, x_reg, y_reg);
    assign b_op = pick(ctrl.uw.b_src, ram_b, alpha_reg, beta_reg, delta_reg, gamma_reg, hs,
                       h6_reg, x_reg, y_reg);

    // multiplier, registered before saturation
    assign prod_w = a_op * b_op;

    always_ff @(posedge aclk) begin
        if (ctrl.exec && ctrl.uw.op == lvrk_pkg::OP_MUL) begin
            prod_reg <= prod_w;
        end
    end

    // scale the magnitude down, truncating toward zero, and clamp
    always_comb begin
        p_neg   = prod_reg[PB-1];
        p_mag   = p_neg ? PB'(-prod_reg) : PB'(prod_reg);
        p_q     = p_mag >> FRAC_BITS;
        p_lim   = p_neg ? {{WB{1'b0}}, lvrk_pkg::WORD_MIN} : {{WB{1'b0}}, lvrk_pkg::WORD_MAX};
        mul_ovf = (p_q > p_lim);
        if (mul_ovf) begin
            mul_res = p_neg ? lvrk_pkg::WORD_MIN : lvrk_pkg::WORD_MAX;
        end else begin
            mul_res = p_neg ? WB'(-p_q[WB-1:0]) : p_q[WB-1:0];
        end
    end

    // saturating add; subtract negates with a clamp on the most negative word
    always_comb begin
        neg_sat = (ctrl.uw.op == lvrk_pkg::OP_SUB) && (b_op == lvrk_pkg::WORD_MIN);
        if (ctrl.uw.op == lvrk_pkg::OP_SUB) begin
            b_eff = neg_sat ? lvrk_pkg::WORD_MAX : -b_op;
        end else begin
            b_eff = b_op;
        end
        sum     = {a_op[WB-1], a_op} + {b_eff[WB-1], b_eff};
        add_ovf = sum[WB] ^ sum[WB-1];
        if (add_ovf) begin
            add_res = sum[WB] ? lvrk_pkg::WORD_MIN : lvrk_pkg::WORD_MAX;
        end else begin
            add_res = sum[WB-1:0];
        end
    end

    // write-back select
    assign is_alu  = ctrl.exec && (ctrl.uw.op == lvrk_pkg::OP_ADD
                                || ctrl.uw.op == lvrk_pkg::OP_SUB);
    assign wr_en   = is_alu || ctrl.mul_wb;
    assign wr_data = ctrl.mul_wb ? mul_res : add_res;

    lvrk_ram #(
        .WIDTH (WB),
        .DEPTH (lvrk_pkg::TMP_DEPTH)
    ) u_tmp (
        .aclk    (aclk),
        .we      (wr_en && ctrl.uw.dst == lvrk_pkg::DST_TMP),
        .waddr   (ctrl.uw.d_addr),
        .wdata   (wr_data),
        .raddr_a (ctrl.uw.a_addr),
        .raddr_b (ctrl.uw.b_addr),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    // coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= lvrk_pkg::RST_PREY_GROWTH;
            beta_reg  <= lvrk_pkg::RST_PREDATION_RATE;
            delta_reg <= lvrk_pkg::RST_PREDATOR_GAIN;
            gamma_reg <= lvrk_pkg::RST_PREDATOR_DEATH;
            step_reg  <= lvrk_pkg::RST_STEP_SIZE;
            h6_reg    <= lvrk_pkg::RST_STEP_SIXTH;
        end else if (cfg_we) begin
            case (cfg_index)
                lvrk_pkg::REG_PREY_GROWTH:    alpha_reg <= cfg_data;
                lvrk_pkg::REG_PREDATION_RATE: beta_reg  <= cfg_data;
                lvrk_pkg::REG_PREDATOR_GAIN:  delta_reg <= cfg_data;
                lvrk_pkg::REG_PREDATOR_DEATH: gamma_reg <= cfg_data;
                lvrk_pkg::REG_STEP_SIZE: begin
                    step_reg <= cfg_data[SB-1:0];
                    h6_reg   <= h6_prod[lvrk_pkg::H6_SHIFT +: HB];
                end
                default: ;
            endcase
        end
    end

    // populations and saturation flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg   <= '0;
            y_reg   <= '0;
            sat_reg <= 1'b0;
        end else begin
            if (ctrl.load) begin
                x_reg <= prey_load;
                y_reg <= predator_load;
            end else if (wr_en && ctrl.uw.dst == lvrk_pkg::DST_X) begin
                x_reg <= wr_data;
            end else if (wr_en && ctrl.uw.dst == lvrk_pkg::DST_Y) begin
                y_reg <= wr_data;
            end
            if (ctrl.load || ctrl.start) begin
                sat_reg <= 1'b0;
            end else if (is_alu && (add_ovf || neg_sat)) begin
                sat_reg <= 1'b1;
            end else if (ctrl.mul_wb && mul_ovf) begin
                sat_reg <= 1'b1;
            end
        end
    end

    assign prey_level     = x_reg;
    assign predator_level = y_reg;
    assign saturated      = sat_reg;

endmodule

FILE: sv/lotka_volterra_rk4_step_top.sv
// ----------------------------------------------------------------------------
// lotka_volterra_rk4_step_top
// Lotka-Volterra predator/prey integrator, one fourth-order Runge-Kutta step
// per step word, Q16.16 saturating arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per item. s_tuser is the kind (0 load, 1 step);
//     on a load, s_tdata carries the new prey and predator populations.
//   m_ channel: one word per item with both populations after the item and
//     a flag that any operation of the item saturated.
//   cfg_ channel: write the coefficients and step size, only while idle;
//     cfg_ready is always high, unknown indexes are dropped.
// Sequencing:
//   A load word goes to the finish state when accepted, then into the output
//   register once it is free. A step word's micro-program runs 32 multiplies
//   (operand read, multiply, scale and clamp) and 37 other micro-instructions
//   (operand read, execute), all through the one multiplier and the two-port
//   scratch RAM, before the finish state hands the result over. One word is
//   in flight at a time; s_tready returns after the hand-over.
// Reset clears the populations to zero and restores the default
// coefficients. A stalled result is held in the output register; a new word
// is accepted meanwhile, and its result waits until the held one is taken.
// ----------------------------------------------------------------------------
module lotka_volterra_rk4_step_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] prey_load, [63:32] predator_load
    input  logic        s_tuser,    // [0] kind
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] prey_now, [63:32] predator_now
    output logic        m_tuser,    // [0] saturated
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    lvrk_pkg::ctrl_t ctrl;
    logic            out_free;
    logic            out_load;
    logic [31:0]     prey_level, predator_level;
    logic            saturated;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [63:0]     m_tdata_reg;
    logic            m_tuser_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    lvrk_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .out_free (out_free),
        .in_ready (s_tready),
        .out_load (out_load),
        .ctrl     (ctrl)
    );

    lvrk_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .prey_load      (s_tdata[31:0]),
        .predator_load  (s_tdata[63:32]),
        .prey_level     (prey_level),
        .predator_level (predator_level),
        .saturated      (saturated)
    );

    // output register: load on hand-over, drop once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {predator_level, prey_level};
            m_tuser_reg <= saturated;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: sv/lvrk_chk.sv
// ----------------------------------------------------------------------------
// lvrk_chk
// Port checker for the integrator, bound to the top level.
// ----------------------------------------------------------------------------
module lvrk_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one word in flight: no acceptance on the following cycle
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // reset leaves no result pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a load into an empty output comes back unchanged via the finish state
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && !m_tvalid
        |=> ##1 m_tvalid && m_tdata == $past(s_tdata, 2) && !m_tuser)
        else $error("load result mismatch");

endmodule

bind lotka_volterra_rk4_step_top lvrk_chk u_lvrk_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Lotka-Volterra RK4 integrator. Load and step
// words go in through bursts with random gaps. The results come back through
// a receiver that stalls in changing patterns. Each result is compared with
// an in-bench Q16.16 saturating model of the integrator. Coefficients and
// step size are reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module tb;

    localparam int     FRAC        = 16;
    localparam longint Q_MAX       = 64'sd2147483647;
    localparam longint Q_MIN       = -Q_MAX - 1;
    localparam int     CYCLE_CAP   = 1000000;
    localparam int     REPORT_CAP  = 10;
    localparam int     TAIL_CYCLES = 200;
    localparam int     PLAN_ROWS   = 23;

    // short names for the directed table
    localparam logic        K_LOAD = lvrk_pkg::KIND_LOAD;
    localparam logic        K_STEP = lvrk_pkg::KIND_STEP;
    localparam logic [31:0] W_MAX  = lvrk_pkg::WORD_MAX;
    localparam logic [31:0] W_MIN  = lvrk_pkg::WORD_MIN;

    typedef struct packed {
        logic [31:0] prey;
        logic [31:0] pred;
        logic        sat;
    } pop_word_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] prey;
        logic [31:0] pred;
        logic        typed;
        pop_word_t   want;
    } plan_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_JITTER,
        RX_THROTTLE
    } rx_mode_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;    // [31:0] prey_load, [63:32] predator_load
    logic        s_tuser   = lvrk_pkg::KIND_LOAD;    // [0] kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;           // [31:0] prey_now, [63:32] predator_now
    logic        m_tuser;           // [0] saturated
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = lvrk_pkg::REG_PREY_GROWTH;
    logic [31:0] cfg_data  = '0;

    // model state and register copy
    longint    coef_alpha, coef_beta, coef_delta, coef_gamma, coef_h;
    longint    prey_lvl, pred_lvl;
    bit        clip_seen;
    pop_word_t pending_pops[$];
    plan_row_t plan [PLAN_ROWS];

    int        fault_count  = 0;
    int        burst_left   = 0;
    int        cycle_count  = 0;
    rx_mode_t  ready_mode   = RX_OPEN;
    int        ready_run    = 0;
    int        ready_period = 2;
    int        ready_tick   = 0;

    lotka_volterra_rk4_step_top #(
        .FRAC_BITS(FRAC)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Q16.16 saturating arithmetic
    // ------------------------------------------------------------------------
    function automatic longint clip_word(input longint v);
        if (v > Q_MAX) begin
            clip_seen = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            clip_seen = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    function automatic longint qadd(input longint a, input longint b);
        return clip_word(a + b);
    endfunction

    // exact product, magnitude truncated by the fraction bits, then clamped
    function automatic longint qmul(input longint a, input longint b);
        longint unsigned ma, mb, mag, lim;
        bit              neg;
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        mag = (ma * mb) >> FRAC;
        lim = Q_MAX + (neg ? 1 : 0);
        if (mag > lim) begin
            clip_seen = 1'b1;
            return neg ? Q_MIN : Q_MAX;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // negating the most negative word saturates
    function automatic longint flip_sign(input longint v);
        if (v == Q_MIN) begin
            clip_seen = 1'b1;
            return Q_MAX;
        end
        return -v;
    endfunction

    function automatic longint qsub(input longint a, input longint b);
        return qadd(a, flip_sign(b));
    endfunction

    function automatic longint prey_slope(input longint x, input longint y);
        return qsub(qmul(coef_alpha, x), qmul(qmul(coef_beta, x), y));
    endfunction

    function automatic longint pred_slope(input longint x, input longint y);
        return qsub(qmul(qmul(coef_delta, x), y), qmul(coef_gamma, y));
    endfunction

    // apply one word to the populations and return the word due back
    function automatic pop_word_t advance_pops(input logic kind, input logic [63:0] data);
        longint    x, y, h2, h6;
        longint    k1a, k1b, k2a, k2b, k3a, k3b, k4a, k4b;
        longint    xa, ya, xb, yb, xc, yc, sa, sb;
        pop_word_t r;
        clip_seen = 1'b0;
        if (kind == lvrk_pkg::KIND_LOAD) begin
            prey_lvl = longint'($signed(data[31:0]));
            pred_lvl = longint'($signed(data[63:32]));
        end else begin
            x   = prey_lvl;
            y   = pred_lvl;
            h2  = coef_h >> 1;
            h6  = coef_h / 6;
            k1a = prey_slope(x, y);
            k1b = pred_slope(x, y);
            xa  = qadd(x, qmul(h2, k1a));
            ya  = qadd(y, qmul(h2, k1b));
            k2a = prey_slope(xa, ya);
            k2b = pred_slope(xa, ya);
            xb  = qadd(x, qmul(h2, k2a));
            yb  = qadd(y, qmul(h2, k2b));
            k3a = prey_slope(xb, yb);
            k3b = pred_slope(xb, yb);
            xc  = qadd(x, qmul(coef_h, k3a));
            yc  = qadd(y, qmul(coef_h, k3b));
            k4a = prey_slope(xc, yc);
            k4b = pred_slope(xc, yc);
            sa  = qadd(qadd(qadd(k1a, qadd(k2a, k2a)), qadd(k3a, k3a)), k4a);
            sb  = qadd(qadd(qadd(k1b, qadd(k2b, k2b)), qadd(k3b, k3b)), k4b);
            prey_lvl = qadd(x, qmul(h6, sa));
            pred_lvl = qadd(y, qmul(h6, sb));
        end
        r.prey = prey_lvl[31:0];
        r.pred = pred_lvl[31:0];
        r.sat  = clip_seen;
        return r;
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_CAP)
            $display("tb: %s", msg);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [31:0] pick_pop();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = $urandom;
            1:       v = 32'd0 - $urandom_range(0, 4 << FRAC);
            default: v = $urandom_range(0, 12 << FRAC);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_coef();
        logic [31:0] v;
        v = $urandom_range(0, 2 << FRAC);
        if ($urandom_range(0, 7) == 0)
            v = 32'd0 - v;
        return v;
    endfunction

    // write one register; the caller drops cfg_valid after the batch
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            lvrk_pkg::REG_PREY_GROWTH:    coef_alpha = longint'($signed(val));
            lvrk_pkg::REG_PREDATION_RATE: coef_beta  = longint'($signed(val));
            lvrk_pkg::REG_PREDATOR_GAIN:  coef_delta = longint'($signed(val));
            lvrk_pkg::REG_PREDATOR_DEATH: coef_gamma = longint'($signed(val));
            lvrk_pkg::REG_STEP_SIZE:      coef_h     = longint'({1'b0, val[30:0]});
            default: ;
        endcase
    endtask

    // program all registers, optionally followed by writes to unused indexes
    task automatic program_regs(input logic [31:0] alpha, input logic [31:0] beta,
                                input logic [31:0] delta, input logic [31:0] gamma,
                                input logic [31:0] h, input bit spare);
        write_reg(lvrk_pkg::REG_PREY_GROWTH, alpha);
        write_reg(lvrk_pkg::REG_PREDATION_RATE, beta);
        write_reg(lvrk_pkg::REG_PREDATOR_GAIN, delta);
        write_reg(lvrk_pkg::REG_PREDATOR_DEATH, gamma);
        write_reg(lvrk_pkg::REG_STEP_SIZE, h);
        if (spare) begin
            for (int i = int'(lvrk_pkg::REG_STEP_SIZE) + 1;
                 i < (1 << lvrk_pkg::CFG_IDX_BITS); i++)
                write_reg(3'(i), $urandom);
        end
        cfg_valid <= 1'b0;
    endtask

    // hold off the sender until every pending result has come back
    task automatic settle_pops();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_pops.size() != 0);
    endtask

    // send one word, opening a new burst after a random gap when due
    task automatic feed(input logic kind, input logic [63:0] data, input bit typed,
                        input pop_word_t want);
        int        gap;
        pop_word_t predicted;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(100, 220);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        predicted = advance_pops(kind, data);
        pending_pops.push_back(typed ? want : predicted);
    endtask

    // mostly a load followed by a run of steps, some stray words in between
    task automatic run_random(input int count);
        int sent;
        int steps;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 39) == 0)
                settle_pops();
            if ($urandom_range(0, 6) != 0) begin
                feed(lvrk_pkg::KIND_LOAD, {pick_pop(), pick_pop()}, 1'b0, '0);
                steps = $urandom_range(1, 12);
                repeat (steps) feed(lvrk_pkg::KIND_STEP, {$urandom, $urandom}, 1'b0, '0);
                sent += steps + 1;
            end else begin
                feed($urandom_range(0, 1) ? lvrk_pkg::KIND_STEP : lvrk_pkg::KIND_LOAD,
                     {$urandom, $urandom}, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: open, jittery or throttled stretches of random length
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (ready_run == 0) begin
            ready_mode   = rx_mode_t'($urandom_range(0, 2));
            ready_run    = $urandom_range(20, 600);
            ready_period = $urandom_range(2, 40);
        end else begin
            ready_run--;
        end
        ready_tick++;
        case (ready_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_JITTER: m_tready <= ($urandom_range(0, 2) != 0);
            default:   m_tready <= (ready_tick % ready_period == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Result check against the oldest pending word
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : rx_check
        pop_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pops.size() == 0) begin
                note_fault($sformatf("unexpected word prey %h predator %h sat %b",
                                     m_tdata[31:0], m_tdata[63:32], m_tuser));
            end else begin
                want = pending_pops.pop_front();
                if (m_tdata[31:0] !== want.prey || m_tdata[63:32] !== want.pred ||
                    m_tuser !== want.sat)
                    note_fault($sformatf(
                        "mismatch prey %h/%h predator %h/%h sat %b/%b (want/got)",
                        want.prey, m_tdata[31:0], want.pred, m_tdata[63:32],
                        want.sat, m_tuser));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        coef_alpha = longint'($signed(lvrk_pkg::RST_PREY_GROWTH));
        coef_beta  = longint'($signed(lvrk_pkg::RST_PREDATION_RATE));
        coef_delta = longint'($signed(lvrk_pkg::RST_PREDATOR_GAIN));
        coef_gamma = longint'($signed(lvrk_pkg::RST_PREDATOR_DEATH));
        coef_h     = longint'(lvrk_pkg::RST_STEP_SIZE);
        prey_lvl   = 0;
        pred_lvl   = 0;

        // kind, prey, predator, typed, expected word
        plan = '{
            '{K_STEP, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0}},
            '{K_LOAD, W_MAX, W_MAX, 1'b1, '{W_MAX, W_MAX, 1'b0}},
            '{K_STEP, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
            '{K_STEP, 32'h0, 32'hFFFF_FFFF, 1'b0, '0},
            '{K_LOAD, W_MIN, W_MIN, 1'b1, '{W_MIN, W_MIN, 1'b0}},
            '{K_STEP, 32'h0, 32'h0, 1'b0, '0},
            '{K_LOAD, W_MIN, W_MAX, 1'b1, '{W_MIN, W_MAX, 1'b0}},
            '{K_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
            '{K_LOAD, W_MAX, W_MIN, 1'b1, '{W_MAX, W_MIN, 1'b0}},
            '{K_STEP, 32'h0, 32'h0, 1'b0, '0},
            '{K_LOAD, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0}},
            '{K_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, 1'b0}},
            '{K_LOAD, 32'h0001_0000, 32'h0000_8000, 1'b1,
              '{32'h0001_0000, 32'h0000_8000, 1'b0}},
            '{K_STEP, 32'h0, 32'h0, 1'b0, '0},
            '{K_STEP, 32'h0, 32'h0, 1'b0, '0},
            '{K_STEP, 32'h0, 32'h0, 1'b0, '0},
            '{K_STEP, 32'h0, 32'h0, 1'b0, '0},
            '{K_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
            '{K_STEP, 32'h0, 32'h0, 1'b0, '0},
            '{K_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1,
              '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0}},
            '{K_STEP, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
            '{K_LOAD, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1,
              '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0}},
            '{K_STEP, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words at the reset coefficients
        foreach (plan[i])
            feed(plan[i].kind, {plan[i].pred, plan[i].prey}, plan[i].typed, plan[i].want);
        run_random(100);

        // typical coefficients, plus writes to unused indexes that must be dropped
        settle_pops();
        program_regs(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                     $urandom_range(64, 16384), 1'b1);
        run_random(100);

        // extremes: largest step, bit 31 of the step word must be dropped
        settle_pops();
        program_regs(W_MAX, W_MIN, W_MAX, W_MIN, 32'hFFFF_FFFF, 1'b0);
        run_random(60);

        // opposite extremes with a zero step
        settle_pops();
        program_regs(W_MIN, W_MAX, W_MIN, W_MAX, 32'h0, 1'b0);
        run_random(60);

        // zero coefficients, largest step
        settle_pops();
        program_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0);
        run_random(40);

        // full-range random registers
        settle_pops();
        program_regs($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
        run_random(80);

        settle_pops();
        program_regs(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                     $urandom_range(64, 16384), 1'b0);
        run_random(100);

        // back to the reset values
        settle_pops();
        program_regs(lvrk_pkg::RST_PREY_GROWTH, lvrk_pkg::RST_PREDATION_RATE,
                     lvrk_pkg::RST_PREDATOR_GAIN, lvrk_pkg::RST_PREDATOR_DEATH,
                     {1'b0, lvrk_pkg::RST_STEP_SIZE}, 1'b0);
        run_random(60);

        // drain, then watch for stray words
        settle_pops();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
sv/lvrk_pkg.sv
sv/lvrk_ram.sv
sv/lvrk_seq.sv
sv/lvrk_dp.sv
sv/lotka_volterra_rk4_step_top.sv
sv/lvrk_chk.sv
sim/tb.sv
